@@ rtl/button_click_hold_detector_defines.svh @@
// Assertion macros shared by the button click and hold detector RTL.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_DEFINES_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define BCHD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bchd assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define BCHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bchd assertion failed");

`else

`define BCHD_ASSERT(lbl, clk, rst_n, prop)
`define BCHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/bchd_pkg.sv @@
// Shared types and constants of the button click and hold detector.
`timescale 1ns / 1ps

package bchd_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] REG_ACTIVE_LOW   = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_DEBOUNCE_MS  = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_HOLD_MS      = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_DOUBLE_MS    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CfgDataBits-1:0] DebounceMsReset = 16'd50;
  localparam logic [CfgDataBits-1:0] HoldMsReset     = 16'd1000;
  localparam logic [CfgDataBits-1:0] DoubleMsReset   = 16'd250;

  // Button state machine modes.
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_DEBOUNCE = 3'd1,
    MODE_PRESSED  = 3'd2,
    MODE_HELD     = 3'd3,
    MODE_WAIT2    = 3'd4,
    MODE_DOUBLE   = 3'd5
  } mode_e;

  // Current configuration as seen by the core.
  typedef struct packed {
    logic                   active_low;
    logic [CfgDataBits-1:0] debounce_ms;
    logic [CfgDataBits-1:0] hold_ms;
    logic [CfgDataBits-1:0] double_click_ms;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic pressed_level;
    logic click_event;
    logic release_event;
    logic hold_event;
    logic double_click_event;
    logic waiting_double;
  } result_t;

endpackage

@@ rtl/bchd_cfg.sv @@
// Configuration register file of the button click and hold detector.
`timescale 1ns / 1ps

module bchd_cfg
  import bchd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index and replace the addressed field.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACTIVE_LOW:  cfg_d.active_low      = cfg_wdata_i[0];
        REG_DEBOUNCE_MS: cfg_d.debounce_ms     = cfg_wdata_i;
        REG_HOLD_MS:     cfg_d.hold_ms         = cfg_wdata_i;
        REG_DOUBLE_MS:   cfg_d.double_click_ms = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Register storage with the documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low      <= 1'b1;
      cfg_q.debounce_ms     <= DebounceMsReset;
      cfg_q.hold_ms         <= HoldMsReset;
      cfg_q.double_click_ms <= DoubleMsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/bchd_core.sv @@
// Button state machine with debounce, hold and double-click timing.
`timescale 1ns / 1ps
`include "button_click_hold_detector_defines.svh"

module bchd_core
  import bchd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        pin_level_i,
  input  logic [31:0] now_ms_i,
  input  cfg_t        cfg_i,
  output result_t     result_o
);

  mode_e                mode_q, mode_d;
  logic                 last_level_q;
  logic [TIME_BITS-1:0] debounce_start_q, debounce_start_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  logic [TIME_BITS-1:0] release_start_q, release_start_d;

  logic [TIME_BITS-1:0] now_t;
  logic                 level;
  logic [TIME_BITS-1:0] dbn_elapsed, press_elapsed, rel_elapsed;
  logic [TIME_BITS-1:0] dbn_limit, hold_limit, dbl_limit;
  logic                 dbn_done, hold_done, in_window;

  // Timestamp reduced or extended to the timer width.
  assign now_t = TIME_BITS'({32'd0, now_ms_i});

  // Polarity correction.
  assign level = pin_level_i ^ cfg_i.active_low;

  // Elapsed times wrap at the timer width and compare unsigned.
  assign dbn_elapsed   = now_t - debounce_start_q;
  assign press_elapsed = now_t - press_start_q;
  assign rel_elapsed   = now_t - release_start_q;
  assign dbn_limit     = TIME_BITS'(cfg_i.debounce_ms);
  assign hold_limit    = TIME_BITS'(cfg_i.hold_ms);
  assign dbl_limit     = TIME_BITS'(cfg_i.double_click_ms);
  assign dbn_done      = (dbn_elapsed >= dbn_limit);
  assign hold_done     = (press_elapsed >= hold_limit);
  assign in_window     = (rel_elapsed <= dbl_limit);

  // Next mode, timestamps and events for the item at hand.
  always_comb begin
    mode_d           = mode_q;
    debounce_start_d = debounce_start_q;
    press_start_d    = press_start_q;
    release_start_d  = release_start_q;
    result_o         = '0;
    result_o.pressed_level = level;

    case (mode_q)
      MODE_DEBOUNCE: begin
        if (dbn_done) begin
          if (level) begin
            press_start_d = now_t;
            mode_d        = MODE_PRESSED;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
      end
      MODE_PRESSED: begin
        if (!level) begin
          result_o.release_event = 1'b1;
          release_start_d        = now_t;
          mode_d                 = MODE_WAIT2;
        end else if (hold_done) begin
          result_o.hold_event = 1'b1;
          mode_d              = MODE_HELD;
        end
      end
      MODE_HELD: begin
        // A release after a hold opens no double-click window.
        if (!level) begin
          result_o.release_event = 1'b1;
          mode_d                 = MODE_IDLE;
        end
      end
      MODE_WAIT2: begin
        if (level && in_window) begin
          result_o.double_click_event = 1'b1;
          mode_d                      = MODE_DOUBLE;
        end else if (!in_window) begin
          result_o.click_event = 1'b1;
          mode_d               = MODE_IDLE;
        end
      end
      MODE_DOUBLE: begin
        if (!level) begin
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        // Idle and unused codes: start debouncing on a level change.
        if (level != last_level_q) begin
          debounce_start_d = now_t;
          mode_d           = MODE_DEBOUNCE;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
    endcase

    result_o.waiting_double = (mode_d == MODE_WAIT2);
  end

  // State registers advance once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= MODE_IDLE;
      last_level_q     <= 1'b0;
      debounce_start_q <= '0;
      press_start_q    <= '0;
      release_start_q  <= '0;
    end else if (step_i) begin
      mode_q           <= mode_d;
      last_level_q     <= level;
      debounce_start_q <= debounce_start_d;
      press_start_q    <= press_start_d;
      release_start_q  <= release_start_d;
    end
  end

  // At most one event is raised per item; bits 4 to 1 are click, release, hold, double.
  `BCHD_ASSERT(a_one_event, clk_i, rst_ni, $onehot0(result_o[4:1]))

  // A hold is only reported out of the pressed mode.
  `BCHD_ASSERT(a_hold_from_pressed, clk_i, rst_ni, !result_o.hold_event || mode_q == MODE_PRESSED)

  // A double click moves the machine to the double-click mode.
  `BCHD_ASSERT(a_double_mode, clk_i, rst_ni, !result_o.double_click_event || mode_d == MODE_DOUBLE)

  // The remembered level follows every item.
  `BCHD_ASSERT_NEXT(a_last_level, clk_i, rst_ni, step_i, last_level_q == $past(level))

endmodule

@@ rtl/button_click_hold_detector.sv @@
// Top level of the button click, hold and double-click detector.
//
//   channel   direction  handshake                  payload
//   in        sink       in_valid_i / in_stall_o    pin_level_i, now_ms_i
//   out       source     out_valid_o / out_stall_i  pressed_level_o .. waiting_double_o
//   cfg       sink       cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// An item is captured in an input register, evaluated combinationally against the button
// state and written to a result register; one item per cycle is sustained while the result
// is not stalled. Reset returns the state machine to idle and the configuration to its
// defaults. A stalled result holds the result register; one further item waits in the
// input register, and in_stall_o rises only when both are full.
`timescale 1ns / 1ps

module button_click_hold_detector
  import bchd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   pin_level_i,
  input  logic [31:0]            now_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   pressed_level_o,
  output logic                   click_event_o,
  output logic                   release_event_o,
  output logic                   hold_event_o,
  output logic                   double_click_event_o,
  output logic                   waiting_double_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  cfg_t        cfg;
  result_t     result;
  result_t     res_q;
  logic        in_vld_q, out_vld_q;
  logic        pin_q;
  logic [31:0] now_q;
  logic        out_adv, step;

  // The result register frees up when empty or taken this cycle.
  assign out_adv    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_adv;
  assign in_stall_o = in_vld_q && !out_adv;

  bchd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bchd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pin_level_i (pin_q),
    .now_ms_i    (now_q),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pin_q <= pin_level_i;
      now_q <= now_ms_i;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign pressed_level_o      = res_q.pressed_level;
  assign click_event_o        = res_q.click_event;
  assign release_event_o      = res_q.release_event;
  assign hold_event_o         = res_q.hold_event;
  assign double_click_event_o = res_q.double_click_event;
  assign waiting_double_o     = res_q.waiting_double;

endmodule
